// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for clocked concurrent checks with asynchronous reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define CHK_ALWAYS(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");

// When the antecedent holds, the consequent must hold in the next cycle.
`define CHK_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ===== rtl/core/sha1md_pkg.sv =====
// ----------------------------------------------------------------------------
// sha1md_pkg
// Types, constants and round functions of the SHA-1 digest unit.
// ----------------------------------------------------------------------------
package sha1md_pkg;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MARK,
		ST_ZERO,
		ST_LEN,
		ST_ROUND,
		ST_ADD,
		ST_EMIT
	} state_t;

	localparam logic [7:0] PAD_MARK   = 8'h80;
	localparam logic [5:0] LEN_SLOT   = 6'd56;
	localparam logic [5:0] LAST_SLOT  = 6'd63;
	localparam logic [6:0] LAST_ROUND = 7'd79;
	localparam logic [2:0] LAST_INDEX = 3'd4;
	localparam int         NUM_WORDS  = 5;

	function automatic logic [31:0] iv_word(input logic [2:0] idx);
		logic [31:0] v;
		case (idx)
			3'd0:    v = 32'h67452301;
			3'd1:    v = 32'hefcdab89;
			3'd2:    v = 32'h98badcfe;
			3'd3:    v = 32'h10325476;
			3'd4:    v = 32'hc3d2e1f0;
			default: v = 32'h0;
		endcase
		return v;
	endfunction

	function automatic logic [31:0] round_k(input logic [6:0] t);
		logic [31:0] k;
		if (t < 7'd20) begin
			k = 32'h5a827999;
		end else if (t < 7'd40) begin
			k = 32'h6ed9eba1;
		end else if (t < 7'd60) begin
			k = 32'h8f1bbcdc;
		end else begin
			k = 32'hca62c1d6;
		end
		return k;
	endfunction

	function automatic logic [31:0] round_f(input logic [6:0] t, input logic [31:0] b,
		input logic [31:0] c, input logic [31:0] d);
		logic [31:0] f;
		if (t < 7'd20) begin
			f = (b & c) | (~b & d);
		end else if (t < 7'd40) begin
			f = b ^ c ^ d;
		end else if (t < 7'd60) begin
			f = (b & c) | (b & d) | (c & d);
		end else begin
			f = b ^ c ^ d;
		end
		return f;
	endfunction

endpackage

// ===== rtl/core/sha1_message_digest_unit.sv =====
// ----------------------------------------------------------------------------
// sha1_message_digest_unit
// SHA-1 over a byte stream: buffers bytes, compresses each 64-byte block
// with one shared round unit, pads the final block and emits five words.
// ----------------------------------------------------------------------------
//
//  channel   direction  payload                                handshake
//  --------  ---------  -------------------------------------  -------------------
//  msg       in         msg_byte[7:0], final_byte              msg_valid/msg_stall
//  dig       out        digest_word[31:0], word_index[2:0],    dig_valid/dig_stall
//                       last_word
//
//  Sequence: an item that does not complete a block only fills the buffer. A
//  completed block adds a compression: 80 rounds through the single round unit
//  and a step that folds the result into the chaining words. The final item
//  adds the padding, one pad byte per step (up to 72 with a second block, plus
//  one step at the length slot), one or two compressions, then 5 output words.
//  Reset: asynchronous, active low; chaining words return to the initial hash,
//  length and byte position to zero. No clearing pass is needed.
//  Stalls: msg_stall is high whenever the unit is not idle; dig_stall holds the
//  current word and its index in place.
//
module sha1_message_digest_unit (
	input  logic        clk,
	input  logic        arst_n,
	// message byte channel
	input  logic        msg_valid,
	output logic        msg_stall,
	input  logic [7:0]  msg_byte,
	input  logic        final_byte,
	// digest word channel
	output logic        dig_valid,
	input  logic        dig_stall,
	output logic [31:0] digest_word,
	output logic [2:0]  word_index,
	output logic        last_word
);

	// Sequencer state and the state to return to after a compression.
	sha1md_pkg::state_t state_q, state_d;
	sha1md_pkg::state_t resume_q, resume_d;

	// Block buffer doubling as the schedule window: 16 words, word 0 at the
	// top. Bytes shift in at the bottom; during rounds the window shifts by
	// one word and the newly expanded word enters at the bottom.
	logic [511:0] buf_q;

	logic [5:0]   pos_q;       // next free byte slot in the block
	logic [63:0]  len_q;       // message length in bits, shifted out while padding
	logic [6:0]   round_q;     // current round of the compression
	logic [2:0]   word_q;      // index of the digest word on the output
	logic [31:0]  a_q, b_q, c_q, d_q, e_q;
	logic [31:0]  chain_q [sha1md_pkg::NUM_WORDS];

	// Byte insertion control
	logic         put_en;
	logic [7:0]   put_val;
	logic         wrap;
	logic         msg_take;
	logic         dig_take;

	// Round unit
	logic [31:0]  w_cur, w_new, w_mix, g_val;

	assign msg_stall   = (state_q != sha1md_pkg::ST_IDLE);
	assign dig_valid   = (state_q == sha1md_pkg::ST_EMIT);
	assign msg_take    = msg_valid && !msg_stall;
	assign dig_take    = dig_valid && !dig_stall;
	assign digest_word = chain_q[word_q];
	assign word_index  = word_q;
	assign last_word   = (word_q == sha1md_pkg::LAST_INDEX);

	// Select the byte going into the buffer this cycle.
	always_comb begin
		put_en  = 1'b0;
		put_val = 8'h00;
		case (state_q)
			sha1md_pkg::ST_IDLE: begin
				put_en  = msg_valid;
				put_val = msg_byte;
			end
			sha1md_pkg::ST_MARK: begin
				put_en  = 1'b1;
				put_val = sha1md_pkg::PAD_MARK;
			end
			sha1md_pkg::ST_ZERO: begin
				put_en  = (pos_q != sha1md_pkg::LEN_SLOT);
				put_val = 8'h00;
			end
			sha1md_pkg::ST_LEN: begin
				put_en  = 1'b1;
				put_val = len_q[63:56];
			end
			default: begin
				put_en  = 1'b0;
				put_val = 8'h00;
			end
		endcase
	end

	assign wrap = put_en && (pos_q == sha1md_pkg::LAST_SLOT);

	// Next state
	always_comb begin
		state_d  = state_q;
		resume_d = resume_q;
		case (state_q)
			sha1md_pkg::ST_IDLE: begin
				if (msg_valid) begin
					if (wrap) begin
						state_d  = sha1md_pkg::ST_ROUND;
						resume_d = final_byte ? sha1md_pkg::ST_MARK : sha1md_pkg::ST_IDLE;
					end else if (final_byte) begin
						state_d = sha1md_pkg::ST_MARK;
					end
				end
			end
			sha1md_pkg::ST_MARK: begin
				if (wrap) begin
					state_d  = sha1md_pkg::ST_ROUND;
					resume_d = sha1md_pkg::ST_ZERO;
				end else begin
					state_d = sha1md_pkg::ST_ZERO;
				end
			end
			sha1md_pkg::ST_ZERO: begin
				if (pos_q == sha1md_pkg::LEN_SLOT) begin
					state_d = sha1md_pkg::ST_LEN;
				end else if (wrap) begin
					state_d  = sha1md_pkg::ST_ROUND;
					resume_d = sha1md_pkg::ST_ZERO;
				end
			end
			sha1md_pkg::ST_LEN: begin
				if (wrap) begin
					state_d  = sha1md_pkg::ST_ROUND;
					resume_d = sha1md_pkg::ST_EMIT;
				end
			end
			sha1md_pkg::ST_ROUND: begin
				if (round_q == sha1md_pkg::LAST_ROUND) begin
					state_d = sha1md_pkg::ST_ADD;
				end
			end
			sha1md_pkg::ST_ADD: begin
				state_d = resume_q;
			end
			sha1md_pkg::ST_EMIT: begin
				if (dig_take && last_word) begin
					state_d = sha1md_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = sha1md_pkg::ST_IDLE;
			end
		endcase
	end

	// Round unit: expand the schedule one word ahead and compute the new a.
	assign w_cur = buf_q[511:480];
	assign w_mix = buf_q[95:64] ^ buf_q[255:224] ^ buf_q[447:416] ^ buf_q[511:480];
	assign w_new = {w_mix[30:0], w_mix[31]};
	assign g_val = {a_q[26:0], a_q[31:27]}
	             + sha1md_pkg::round_f(round_q, b_q, c_q, d_q)
	             + e_q + sha1md_pkg::round_k(round_q) + w_cur;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= sha1md_pkg::ST_IDLE;
			resume_q <= sha1md_pkg::ST_IDLE;
			pos_q    <= 6'd0;
			len_q    <= 64'd0;
			round_q  <= 7'd0;
			word_q   <= 3'd0;
			for (int i = 0; i < sha1md_pkg::NUM_WORDS; i++) begin
				chain_q[i] <= sha1md_pkg::iv_word(3'(i));
			end
		end else begin
			state_q  <= state_d;
			resume_q <= resume_d;

			// Advance the byte slot on every inserted byte; wraps to 0 on a full block.
			if (put_en) begin
				pos_q <= pos_q + 6'd1;
			end

			// Count message bits on accepted items; drain the length while padding.
			if (msg_take) begin
				len_q <= len_q + 64'd8;
			end else if (state_q == sha1md_pkg::ST_LEN) begin
				len_q <= {len_q[55:0], 8'h00};
			end

			if (state_q == sha1md_pkg::ST_ROUND) begin
				round_q <= (round_q == sha1md_pkg::LAST_ROUND) ? 7'd0 : round_q + 7'd1;
			end

			// Fold the compression into the chaining words.
			if (state_q == sha1md_pkg::ST_ADD) begin
				chain_q[0] <= chain_q[0] + a_q;
				chain_q[1] <= chain_q[1] + b_q;
				chain_q[2] <= chain_q[2] + c_q;
				chain_q[3] <= chain_q[3] + d_q;
				chain_q[4] <= chain_q[4] + e_q;
			end

			// Step through the digest words; reinitialize after the last one.
			if (dig_take) begin
				if (last_word) begin
					word_q <= 3'd0;
					for (int i = 0; i < sha1md_pkg::NUM_WORDS; i++) begin
						chain_q[i] <= sha1md_pkg::iv_word(3'(i));
					end
				end else begin
					word_q <= word_q + 3'd1;
				end
			end
		end
	end

	// Payload registers: buffer/window and working variables.
	always_ff @(posedge clk) begin
		if (put_en) begin
			buf_q <= {buf_q[503:0], put_val};
		end else if (state_q == sha1md_pkg::ST_ROUND) begin
			buf_q <= {buf_q[479:0], w_new};
		end

		if (wrap) begin
			a_q <= chain_q[0];
			b_q <= chain_q[1];
			c_q <= chain_q[2];
			d_q <= chain_q[3];
			e_q <= chain_q[4];
		end else if (state_q == sha1md_pkg::ST_ROUND) begin
			a_q <= g_val;
			b_q <= a_q;
			c_q <= {b_q[1:0], b_q[31:2]};
			d_q <= c_q;
			e_q <= d_q;
		end
	end

endmodule

// ===== rtl/core/sha1md_checker.sv =====
// ----------------------------------------------------------------------------
// sha1md_checker
// Port-level checks on the digest word sequence of the SHA-1 unit.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sha1md_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        msg_stall,
	input logic        dig_valid,
	input logic        dig_stall,
	input logic [31:0] digest_word,
	input logic [2:0]  word_index,
	input logic        last_word
);

	// last flag marks exactly the fifth word
	`CHK_ALWAYS(a_last_flag, clk, arst_n, !dig_valid || (last_word == (word_index == sha1md_pkg::LAST_INDEX)))

	// no message item is taken while digest words are pending
	`CHK_ALWAYS(a_busy_emit, clk, arst_n, !dig_valid || msg_stall)

	// words leave in order with no gaps
	`CHK_NEXT(a_word_order, clk, arst_n, dig_valid && !dig_stall && !last_word, dig_valid && (word_index == $past(word_index) + 3'd1))

	// digest ends after the last word
	`CHK_NEXT(a_digest_end, clk, arst_n, dig_valid && !dig_stall && last_word, !dig_valid)

	// stalled word holds
	`CHK_NEXT(a_stall_hold, clk, arst_n, dig_valid && dig_stall, dig_valid && $stable(digest_word) && $stable(word_index))

endmodule

bind sha1_message_digest_unit sha1md_checker u_sha1md_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.msg_stall   (msg_stall),
	.dig_valid   (dig_valid),
	.dig_stall   (dig_stall),
	.digest_word (digest_word),
	.word_index  (word_index),
	.last_word   (last_word)
);

// ===== tb/sha1_digest_sb_pkg.sv =====
// ----------------------------------------------------------------------------
// sha1_digest_sb_pkg
// Digest predictor and word scoreboard for the SHA-1 digest unit bench.
// ----------------------------------------------------------------------------
package sha1_digest_sb_pkg;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_REPORTS = 10;

	localparam bit [31:0] SHA1_INIT [sha1md_pkg::NUM_WORDS] = '{
		32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476, 32'hc3d2e1f0
	};
	localparam bit [31:0] K_CHOOSE = 32'h5a827999;
	localparam bit [31:0] K_PARITY = 32'h6ed9eba1;
	localparam bit [31:0] K_MAJOR  = 32'h8f1bbcdc;
	localparam bit [31:0] K_TAIL   = 32'hca62c1d6;

	typedef struct packed {
		bit [31:0] word;
		bit [2:0]  idx;
		bit        last;
	} digest_entry_t;

	class sha1_digest_scoreboard;
		bit [31:0]     chain [sha1md_pkg::NUM_WORDS];
		bit [7:0]      blk [64];
		bit [5:0]      fill;
		bit [63:0]     msg_bits;
		digest_entry_t pending [$];
		int            words_checked;
		int            mismatches;

		function new();
			reset_state();
		endfunction

		function void reset_state();
			for (int i = 0; i < sha1md_pkg::NUM_WORDS; i++) chain[i] = SHA1_INIT[i];
			fill = '0;
			msg_bits = '0;
		endfunction

		// Store one byte; compress when the 64-byte block is full.
		function void push_byte(bit [7:0] v);
			bit [31:0] sched [16];
			bit [31:0] a, b, c, d, e, f, k, mixed;
			int s;
			blk[fill] = v;
			fill = fill + 6'd1;
			if (fill != 6'd0) return;
			for (int t = 0; t < 16; t++)
				sched[t] = {blk[4*t], blk[4*t+1], blk[4*t+2], blk[4*t+3]};
			a = chain[0];
			b = chain[1];
			c = chain[2];
			d = chain[3];
			e = chain[4];
			for (int t = 0; t < 80; t++) begin
				s = t % 16;
				if (t >= 16) begin
					mixed = sched[(s + 13) % 16] ^ sched[(s + 8) % 16]
						^ sched[(s + 2) % 16] ^ sched[s];
					sched[s] = {mixed[30:0], mixed[31]};
				end
				if (t < 20) begin
					f = (b & c) | (~b & d);
					k = K_CHOOSE;
				end else if (t < 40) begin
					f = b ^ c ^ d;
					k = K_PARITY;
				end else if (t < 60) begin
					f = (b & c) | (b & d) | (c & d);
					k = K_MAJOR;
				end else begin
					f = b ^ c ^ d;
					k = K_TAIL;
				end
				mixed = {a[26:0], a[31:27]} + f + e + k + sched[s];
				e = d;
				d = c;
				c = {b[1:0], b[31:2]};
				b = a;
				a = mixed;
			end
			chain[0] += a;
			chain[1] += b;
			chain[2] += c;
			chain[3] += d;
			chain[4] += e;
		endfunction

		// Account for one accepted message byte; on the final byte pad,
		// append the bit length and queue the five digest words.
		function void note_byte(bit [7:0] v, bit fin);
			bit [63:0] total;
			msg_bits += 64'd8;
			push_byte(v);
			if (!fin) return;
			total = msg_bits;
			push_byte(sha1md_pkg::PAD_MARK);
			while (fill != sha1md_pkg::LEN_SLOT) push_byte(8'h00);
			for (int i = 7; i >= 0; i--) push_byte(total[8*i +: 8]);
			for (int i = 0; i < sha1md_pkg::NUM_WORDS; i++)
				pending.push_back('{word: chain[i], idx: 3'(i),
					last: (3'(i) == sha1md_pkg::LAST_INDEX)});
			reset_state();
		endfunction

		function void note_failure(string what);
			mismatches++;
			if (mismatches <= MAX_REPORTS) $display("%s", what);
		endfunction

		// Compare one digest word with the oldest outstanding one.
		function void check_word(logic [31:0] word, logic [2:0] idx, logic last);
			digest_entry_t exp_w;
			if (pending.size() == 0) begin
				note_failure($sformatf("unexpected digest word %08h idx %0d last %0b",
					word, idx, last));
				return;
			end
			exp_w = pending.pop_front();
			words_checked++;
			if (word !== exp_w.word || idx !== exp_w.idx || last !== exp_w.last)
				note_failure($sformatf(
					"digest mismatch: expected %08h idx %0d last %0b, got %08h idx %0d last %0b",
					exp_w.word, exp_w.idx, exp_w.last, word, idx, last));
		endfunction

		function int outstanding();
			return pending.size();
		endfunction
	endclass

endpackage

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the SHA-1 digest unit: feeds byte messages in
// bursts, predicts every digest word and compares each word as it leaves.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int ITEM_TARGET  = 330;
	localparam int HOLD_CYCLES  = 400;
	localparam int DRAIN_CYCLES = 200;
	localparam int CYCLE_LIMIT  = 300000;

	typedef enum {RX_FREE, RX_LIGHT, RX_HEAVY} rx_mode_t;

	logic        clk;
	logic        arst_n;
	logic        msg_valid;
	logic        msg_stall;
	logic [7:0]  msg_byte;
	logic        final_byte;
	logic        dig_valid;
	logic        dig_stall;
	logic [31:0] digest_word;
	logic [2:0]  word_index;
	logic        last_word;

	sha1_digest_sb_pkg::sha1_digest_scoreboard sb = new();

	int items_sent;
	int msgs_sent;
	int words_seen;
	int burst_left;
	bit hold_done;

	sha1_message_digest_unit u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.msg_valid   (msg_valid),
		.msg_stall   (msg_stall),
		.msg_byte    (msg_byte),
		.final_byte  (final_byte),
		.dig_valid   (dig_valid),
		.dig_stall   (dig_stall),
		.digest_word (digest_word),
		.word_index  (word_index),
		.last_word   (last_word)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Offer one byte at the falling edge and hold it until the unit takes it.
	// Between bursts the sender goes quiet for a random gap; valid never
	// looks at the stall.
	task automatic send_byte(input bit [7:0] v, input bit fin);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(1, 10);
			repeat (gap) begin
				@(negedge clk);
				msg_valid <= 1'b0;
			end
			// mostly short bursts, now and then a long run with no idling
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 150)
				: $urandom_range(1, 12);
		end
		@(negedge clk);
		msg_valid  <= 1'b1;
		msg_byte   <= v;
		final_byte <= fin;
		do @(posedge clk); while (msg_stall);
		sb.note_byte(v, fin);
		items_sent++;
		burst_left--;
	endtask

	// Send a whole message of random bytes; the last one carries the flag.
	task automatic send_message(input int len);
		for (int i = 0; i < len; i++)
			send_byte(8'($urandom_range(0, 255)), i == len - 1);
		msgs_sent++;
	endtask

	// Main stimulus: reset, directed messages, random messages, drain.
	initial begin : stimulus
		int len;
		int odd_lens [3];
		odd_lens   = '{57, 63, 65};
		arst_n     = 1'b0;
		msg_valid  = 1'b0;
		msg_byte   = 8'h00;
		final_byte = 1'b0;
		burst_left = 0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// single-byte messages: extremes and alternating bit patterns
		send_byte(8'h00, 1'b1);
		send_byte(8'hff, 1'b1);
		send_byte(8'h80, 1'b1);
		send_byte(8'h55, 1'b1);
		send_byte(8'haa, 1'b1);
		msgs_sent += 5;
		// the classic three-byte "abc" message
		send_byte(8'h61, 1'b0);
		send_byte(8'h62, 1'b0);
		send_byte(8'h63, 1'b1);
		msgs_sent++;
		send_message(12);

		// padding boundaries: length fits exactly, length spills into an
		// extra block, and a message that fills a block on its own
		send_message(55);
		send_message(56);
		send_message(64);

		// random traffic, mostly short messages with a few near the block size
		while (items_sent < ITEM_TARGET) begin
			if ($urandom_range(0, 4) == 0) len = odd_lens[$urandom_range(0, 2)];
			else len = $urandom_range(1, 30);
			// trim the last message so the run lands on the item target
			if (len > ITEM_TARGET - items_sent) len = ITEM_TARGET - items_sent;
			send_message(len);
		end

		@(negedge clk);
		msg_valid <= 1'b0;

		// wait for every predicted word, then let any stray output show up
		while (sb.outstanding() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Covered %0d messages in %0d bytes, %0d digest words checked,",
			msgs_sent, items_sent, sb.words_checked);
		$display("with padding spills, full blocks, bursty input and a long output hold.");
		if (sb.mismatches == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("%0d mismatches", sb.mismatches);
			$display("CHECKS FAILED");
		end
		$finish;
	end

	// Receiver stall: segments of free flow, light and heavy stalling, and
	// once a long hold so the unit backs up and stalls the byte channel.
	initial begin : rx_stall
		int seg_len;
		rx_mode_t mode;
		dig_stall = 1'b0;
		hold_done = 1'b0;
		@(posedge arst_n);
		forever begin
			if (!hold_done && words_seen >= 12) begin
				hold_done = 1'b1;
				repeat (HOLD_CYCLES) begin
					@(negedge clk);
					dig_stall <= 1'b1;
				end
			end
			seg_len = $urandom_range(1, 40);
			mode = rx_mode_t'($urandom_range(0, 2));
			repeat (seg_len) begin
				@(negedge clk);
				case (mode)
					RX_FREE:  dig_stall <= 1'b0;
					RX_LIGHT: dig_stall <= ($urandom_range(0, 3) == 0);
					default:  dig_stall <= ($urandom_range(0, 3) != 0);
				endcase
			end
		end
	end

	// Check every digest word the moment it is accepted.
	always @(posedge clk) begin
		if (arst_n && dig_valid === 1'b1 && dig_stall == 1'b0) begin
			sb.check_word(digest_word, word_index, last_word);
			words_seen++;
		end
	end

	// Hard stop if the run hangs.
	initial begin : watchdog
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("timeout after %0d cycles", CYCLE_LIMIT);
		$display("CHECKS FAILED");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/sha1md_pkg.sv
rtl/core/sha1_message_digest_unit.sv
rtl/core/sha1md_checker.sv
tb/sha1_digest_sb_pkg.sv
tb/tb.sv
